/* src/lasx_pkg.sv */
// Package for the 8-bit CPU load/ALU subset executor.
// Reset values of the register file, flag bit positions, shared types.
// No dependencies.
package lasx_pkg;

   localparam logic [7:0]  ACC_RESET   = 8'h01;
   localparam logic [7:0]  FLAG_RESET  = 8'hB0;
   localparam logic [15:0] BC_RESET    = 16'h0013;
   localparam logic [15:0] DE_RESET    = 16'h00D8;
   localparam logic [15:0] HL_RESET    = 16'h014D;
   localparam logic [15:0] SP_RESET    = 16'hFFFE;
   localparam logic [15:0] PC_RESET    = 16'h0100;

   localparam int FLAG_Z = 7;
   localparam int FLAG_N = 6;
   localparam int FLAG_H = 5;
   localparam int FLAG_C = 4;

   typedef struct packed {
      logic [7:0]  acc;
      logic [7:0]  flags;
      logic [15:0] bc;
      logic [15:0] de;
      logic [15:0] hl;
      logic [15:0] sp;
      logic [15:0] pc;
   } regs_type;

   typedef struct packed {
      logic [7:0] opcode;
      logic [7:0] imm_low;
      logic [7:0] imm_high;
      logic [7:0] operand_byte;
   } instr_type;

   typedef struct packed {
      logic        write_enable;
      logic [15:0] write_addr;
      logic [15:0] write_data;
      logic        write_word;
      logic        unknown_op;
   } mem_type;

endpackage

/* src/lasx_exec.sv */
// Combinational execute logic for one instruction.
// Depends on lasx_pkg.
module lasx_exec (
   input  lasx_pkg::instr_type instr,
   input  lasx_pkg::regs_type  regs,
   output lasx_pkg::regs_type  regs_next,
   output lasx_pkg::mem_type   mem_out
);

   logic [7:0]  op, lo, mem, v, r, src;
   logic [3:0]  row, col;
   logic [2:0]  r8;
   logic [15:0] imm16, pair, jr_target;
   logic [16:0] sum;
   logic [12:0] hsum;
   logic [8:0]  da;
   logic        take, isinc;
   lasx_pkg::regs_type n;
   lasx_pkg::mem_type  m;

   function automatic logic [7:0] get8(input lasx_pkg::regs_type g, input logic [2:0] i);
      case (i)
         3'd0: get8 = g.bc[15:8];
         3'd1: get8 = g.bc[7:0];
         3'd2: get8 = g.de[15:8];
         3'd3: get8 = g.de[7:0];
         3'd4: get8 = g.hl[15:8];
         3'd5: get8 = g.hl[7:0];
         default: get8 = g.acc;
      endcase
   endfunction

   function automatic lasx_pkg::regs_type set8(input lasx_pkg::regs_type g,
                                               input logic [2:0] i, input logic [7:0] d);
      lasx_pkg::regs_type t;
      t = g;
      case (i)
         3'd0: t.bc[15:8] = d;
         3'd1: t.bc[7:0]  = d;
         3'd2: t.de[15:8] = d;
         3'd3: t.de[7:0]  = d;
         3'd4: t.hl[15:8] = d;
         3'd5: t.hl[7:0]  = d;
         3'd7: t.acc      = d;
         default: t = g;
      endcase
      return t;
   endfunction

   function automatic lasx_pkg::regs_type set16(input lasx_pkg::regs_type g,
                                                input logic [1:0] i, input logic [15:0] d);
      lasx_pkg::regs_type t;
      t = g;
      case (i)
         2'd0: t.bc = d;
         2'd1: t.de = d;
         2'd2: t.hl = d;
         default: t.sp = d;
      endcase
      return t;
   endfunction

   always_comb begin
      op    = instr.opcode;
      lo    = instr.imm_low;
      mem   = instr.operand_byte;
      row   = op[7:4];
      col   = op[3:0];
      r8    = op[5:3];
      imm16 = {instr.imm_high, lo};
      jr_target = regs.pc + 16'd2 + {{8{lo[7]}}, lo};
      case (row[1:0])
         2'd0: pair = regs.bc;
         2'd1: pair = regs.de;
         2'd2: pair = regs.hl;
         default: pair = regs.sp;
      endcase
      n = regs;
      n.pc = regs.pc + 16'd1;
      m = '0;
      take = 1'b1;
      isinc = 1'b0;
      v = 8'h00; r = 8'h00; src = 8'h00;
      sum = '0; hsum = '0; da = '0;
      if (row == 4'h4) begin
         src = (op[2:0] == 3'd6) ? mem : get8(regs, op[2:0]);
         n = set8(regs, r8, src);
         n.pc = regs.pc + 16'd1;
      end else if (op >= 8'h50) begin
         m.unknown_op = 1'b1;
      end else begin
         case (col)
            4'h0, 4'h8: begin
               if (op == 8'h08) begin
                  m.write_enable = 1'b1;
                  m.write_addr = imm16;
                  m.write_data = regs.sp;
                  m.write_word = 1'b1;
                  n.pc = regs.pc + 16'd3;
               end else if (op != 8'h00 && op != 8'h10) begin
                  case (op)
                     8'h20: take = !regs.flags[lasx_pkg::FLAG_Z];
                     8'h28: take = regs.flags[lasx_pkg::FLAG_Z];
                     8'h30: take = !regs.flags[lasx_pkg::FLAG_C];
                     8'h38: take = regs.flags[lasx_pkg::FLAG_C];
                     default: take = 1'b1;
                  endcase
                  n.pc = take ? jr_target : regs.pc + 16'd2;
               end
            end
            4'h1: begin
               n = set16(regs, row[1:0], imm16);
               n.pc = regs.pc + 16'd3;
            end
            4'h2: begin
               m.write_enable = 1'b1;
               m.write_data = {8'h00, regs.acc};
               m.write_addr = row[1] ? regs.hl : pair;
               if (row == 4'h2) n.hl = regs.hl + 16'd1;
               if (row == 4'h3) n.hl = regs.hl - 16'd1;
            end
            4'hA: begin
               n.acc = mem;
               if (row == 4'h2) n.hl = regs.hl + 16'd1;
               if (row == 4'h3) n.hl = regs.hl - 16'd1;
            end
            4'h3: begin
               n = set16(regs, row[1:0], pair + 16'd1);
               n.pc = regs.pc + 16'd1;
            end
            4'hB: begin
               n = set16(regs, row[1:0], pair - 16'd1);
               n.pc = regs.pc + 16'd1;
            end
            4'h4, 4'hC, 4'h5, 4'hD: begin
               isinc = !col[0];
               v = (r8 == 3'd6) ? mem : get8(regs, r8);
               r = isinc ? v + 8'd1 : v - 8'd1;
               if (r8 == 3'd6) begin
                  m.write_enable = 1'b1;
                  m.write_addr = regs.hl;
                  m.write_data = {8'h00, r};
               end else begin
                  n = set8(regs, r8, r);
                  n.pc = regs.pc + 16'd1;
               end
               n.flags[lasx_pkg::FLAG_Z] = (r == 8'h00);
               n.flags[lasx_pkg::FLAG_N] = !isinc;
               n.flags[lasx_pkg::FLAG_H] = isinc ? (v[3:0] == 4'hF) : (v[3:0] == 4'h0);
            end
            4'h6, 4'hE: begin
               if (r8 == 3'd6) begin
                  m.write_enable = 1'b1;
                  m.write_addr = regs.hl;
                  m.write_data = {8'h00, lo};
               end else begin
                  n = set8(regs, r8, lo);
               end
               n.pc = regs.pc + 16'd2;
            end
            4'h9: begin
               sum  = {1'b0, regs.hl} + {1'b0, pair};
               hsum = {1'b0, regs.hl[11:0]} + {1'b0, pair[11:0]};
               n.hl = sum[15:0];
               n.flags[lasx_pkg::FLAG_N] = 1'b0;
               n.flags[lasx_pkg::FLAG_H] = hsum[12];
               n.flags[lasx_pkg::FLAG_C] = sum[16];
            end
            4'h7: begin
               case (row[1:0])
                  2'd0: begin
                     n.acc = {regs.acc[6:0], regs.acc[7]};
                     n.flags[7:4] = {3'b000, regs.acc[7]};
                  end
                  2'd1: begin
                     n.acc = {regs.acc[6:0], regs.flags[lasx_pkg::FLAG_C]};
                     n.flags[7:4] = {3'b000, regs.acc[7]};
                  end
                  2'd2: begin
                     // DAA: the 0x60 step can carry past 8 bits, only low byte kept
                     da = {1'b0, regs.acc};
                     if (!regs.flags[lasx_pkg::FLAG_N]) begin
                        if (regs.flags[lasx_pkg::FLAG_C] || regs.acc > 8'h99) begin
                           da = da + 9'h060;
                           n.flags[lasx_pkg::FLAG_C] = 1'b1;
                        end
                        if (regs.flags[lasx_pkg::FLAG_H] || da[3:0] > 4'h9)
                           da = da + 9'h006;
                     end else begin
                        if (regs.flags[lasx_pkg::FLAG_C]) da = da - 9'h060;
                        if (regs.flags[lasx_pkg::FLAG_H]) da = da - 9'h006;
                     end
                     n.acc = da[7:0];
                     n.flags[lasx_pkg::FLAG_Z] = (da[7:0] == 8'h00);
                     n.flags[lasx_pkg::FLAG_H] = 1'b0;
                  end
                  default: begin
                     n.flags[lasx_pkg::FLAG_N] = 1'b0;
                     n.flags[lasx_pkg::FLAG_H] = 1'b0;
                     n.flags[lasx_pkg::FLAG_C] = 1'b1;
                  end
               endcase
            end
            default: begin
               case (row[1:0])
                  2'd0: begin
                     n.acc = {regs.acc[0], regs.acc[7:1]};
                     n.flags[7:4] = {3'b000, regs.acc[0]};
                  end
                  2'd1: begin
                     n.acc = {regs.flags[lasx_pkg::FLAG_C], regs.acc[7:1]};
                     n.flags[7:4] = {3'b000, regs.acc[0]};
                  end
                  2'd2: begin
                     n.acc = ~regs.acc;
                     n.flags[lasx_pkg::FLAG_N] = 1'b1;
                     n.flags[lasx_pkg::FLAG_H] = 1'b1;
                  end
                  default: begin
                     n.flags[lasx_pkg::FLAG_N] = 1'b0;
                     n.flags[lasx_pkg::FLAG_H] = 1'b0;
                     n.flags[lasx_pkg::FLAG_C] = !regs.flags[lasx_pkg::FLAG_C];
                  end
               endcase
            end
         endcase
      end
      regs_next = n;
      mem_out   = m;
   end

endmodule

/* src/cpu_load_alu_subset_execute.sv */
// Top level of the 8-bit CPU load/ALU subset executor.
// Depends on lasx_pkg and lasx_exec.
//
//   channel | ports                        | direction
//   req     | req_valid/req_stall + 4 flds | in, one instruction per beat
//   rsp     | rsp_valid/rsp_stall + 12 flds| out, one result per beat
//
// One instruction per cycle while req_stall is low: the execute logic sits
// between the register file and the result register, which loads on accept.
// Reset (synchronous) loads the power-on register values and empties the output.
// req_stall is high only while a result is held and rsp_stall is high, so an
// unstalled consumer sees one beat per cycle with no bubbles.
module cpu_load_alu_subset_execute (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_opcode,
   input  logic [7:0]  req_imm_low,
   input  logic [7:0]  req_imm_high,
   input  logic [7:0]  req_operand_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_write_enable,
   output logic [15:0] rsp_write_addr,
   output logic [15:0] rsp_write_data,
   output logic        rsp_write_word,
   output logic [15:0] rsp_next_pc,
   output logic [7:0]  rsp_acc_out,
   output logic [7:0]  rsp_flags_out,
   output logic [15:0] rsp_bc_out,
   output logic [15:0] rsp_de_out,
   output logic [15:0] rsp_hl_out,
   output logic [15:0] rsp_sp_out,
   output logic        rsp_unknown_op
);

   lasx_pkg::regs_type  regs_ff, regs_in;
   lasx_pkg::mem_type   mem_ff, mem_nx;
   lasx_pkg::instr_type instr;
   logic                valid_ff, valid_in, accept;

   assign instr     = '{req_opcode, req_imm_low, req_imm_high, req_operand_byte};
   assign req_stall = valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign valid_in  = accept || (valid_ff && rsp_stall);

   lasx_exec u_exec (
      .instr     (instr),
      .regs      (regs_ff),
      .regs_next (regs_in),
      .mem_out   (mem_nx)
   );

   // Architectural state lives in regs_ff and doubles as the result payload.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         regs_ff  <= '{lasx_pkg::ACC_RESET, lasx_pkg::FLAG_RESET, lasx_pkg::BC_RESET,
                       lasx_pkg::DE_RESET, lasx_pkg::HL_RESET, lasx_pkg::SP_RESET,
                       lasx_pkg::PC_RESET};
      end else begin
         valid_ff <= valid_in;
         if (accept) regs_ff <= regs_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) mem_ff <= mem_nx;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_write_enable = mem_ff.write_enable;
   assign rsp_write_addr   = mem_ff.write_addr;
   assign rsp_write_data   = mem_ff.write_data;
   assign rsp_write_word   = mem_ff.write_word;
   assign rsp_unknown_op   = mem_ff.unknown_op;
   assign rsp_next_pc      = regs_ff.pc;
   assign rsp_acc_out      = regs_ff.acc;
   assign rsp_flags_out    = regs_ff.flags;
   assign rsp_bc_out       = regs_ff.bc;
   assign rsp_de_out       = regs_ff.de;
   assign rsp_hl_out       = regs_ff.hl;
   assign rsp_sp_out       = regs_ff.sp;

endmodule

/* src/lasx_checker.sv */
// Port-level checker for the executor, bound to the top level.
// Depends on nothing beyond the top level's ports.
module lasx_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_write_enable,
   input logic        rsp_write_word,
   input logic [15:0] rsp_write_data,
   input logic [7:0]  rsp_flags_out,
   input logic        rsp_unknown_op
);

   a_beat_out: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("accepted beat produced no result");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp_flags_out))
      else $error("stalled result changed");

   a_flag_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_flags_out[3:0] == 4'h0)
      else $error("flag low nibble set");

   a_unknown_nowrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_unknown_op || !rsp_write_enable)) |->
      (!rsp_write_word && rsp_write_data == 16'h0000))
      else $error("write reported without write enable");

endmodule

bind cpu_load_alu_subset_execute lasx_checker u_lasx_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_write_enable (rsp_write_enable),
   .rsp_write_word   (rsp_write_word),
   .rsp_write_data   (rsp_write_data),
   .rsp_flags_out    (rsp_flags_out),
   .rsp_unknown_op   (rsp_unknown_op)
);

/* test/tb.sv */
// Testbench for cpu_load_alu_subset_execute: directed and random instruction beats
// checked against an in-bench predictor of the register file and memory writes.
// Depends on lasx_pkg and the block under test.
module tb;

   typedef struct packed {
      logic        we;
      logic [15:0] waddr;
      logic [15:0] wdata;
      logic        wword;
      logic [15:0] pc;
      logic [7:0]  acc;
      logic [7:0]  flags;
      logic [15:0] bc;
      logic [15:0] de;
      logic [15:0] hl;
      logic [15:0] sp;
      logic        unk;
   } exec_result_type;

   // Predicts the CPU state beat by beat and holds expected results in order.
   class exec_scoreboard;
      logic [7:0]  acc, flags;
      logic [15:0] bc, de, hl, sp, pc;
      exec_result_type pending[$];
      int          mismatches;

      function void power_on();
         acc = lasx_pkg::ACC_RESET; flags = lasx_pkg::FLAG_RESET;
         bc = lasx_pkg::BC_RESET; de = lasx_pkg::DE_RESET;
         hl = lasx_pkg::HL_RESET; sp = lasx_pkg::SP_RESET; pc = lasx_pkg::PC_RESET;
         mismatches = 0;
      endfunction

      function logic [7:0] rd8(logic [2:0] i);
         case (i)
            3'd0: return bc[15:8];
            3'd1: return bc[7:0];
            3'd2: return de[15:8];
            3'd3: return de[7:0];
            3'd4: return hl[15:8];
            3'd5: return hl[7:0];
            default: return acc;
         endcase
      endfunction

      function void wr8(logic [2:0] i, logic [7:0] v);
         case (i)
            3'd0: bc[15:8] = v;
            3'd1: bc[7:0] = v;
            3'd2: de[15:8] = v;
            3'd3: de[7:0] = v;
            3'd4: hl[15:8] = v;
            3'd5: hl[7:0] = v;
            3'd7: acc = v;
            default: ;
         endcase
      endfunction

      function logic [15:0] rd16(logic [1:0] i);
         case (i)
            2'd0: return bc;
            2'd1: return de;
            2'd2: return hl;
            default: return sp;
         endcase
      endfunction

      function void wr16(logic [1:0] i, logic [15:0] v);
         case (i)
            2'd0: bc = v;
            2'd1: de = v;
            2'd2: hl = v;
            default: sp = v;
         endcase
      endfunction

      function logic [7:0] incdec(logic [7:0] v, bit dec);
         logic [7:0] r;
         r = dec ? v - 8'd1 : v + 8'd1;
         flags[lasx_pkg::FLAG_Z] = (r == 8'd0);
         flags[lasx_pkg::FLAG_N] = dec;
         flags[lasx_pkg::FLAG_H] = dec ? (v[3:0] == 4'h0) : (v[3:0] == 4'hF);
         return r;
      endfunction

      function void rot_flags(logic c);
         flags[lasx_pkg::FLAG_Z] = 1'b0; flags[lasx_pkg::FLAG_N] = 1'b0;
         flags[lasx_pkg::FLAG_H] = 1'b0;
         flags[lasx_pkg::FLAG_C] = c;
      endfunction

      function void note_instr(logic [7:0] op, logic [7:0] lo, logic [7:0] hi,
                               logic [7:0] mem);
         exec_result_type e;
         logic [15:0] nxt, imm16, jr, other;
         logic [1:0]  row;
         logic [3:0]  col;
         logic [2:0]  r8;
         logic [16:0] sum;
         logic [8:0]  a9;
         logic [7:0]  a;
         bit          take;
         nxt = pc + 16'd1;
         imm16 = {hi, lo};
         jr = pc + 16'd2 + {{8{lo[7]}}, lo};
         row = op[5:4]; col = op[3:0]; r8 = op[5:3];
         e = '{default: '0};
         if (op[7:4] == 4'h4) begin
            wr8(r8, (op[2:0] == 3'd6) ? mem : rd8(op[2:0]));
         end else if (op >= 8'h50) begin
            e.unk = 1'b1;
         end else begin
            case (col)
               4'h0, 4'h8: begin
                  if (op == 8'h08) begin
                     e.we = 1'b1; e.waddr = imm16; e.wdata = sp; e.wword = 1'b1;
                     nxt = pc + 16'd3;
                  end else if (op != 8'h00 && op != 8'h10) begin
                     take = 1'b1;
                     if (op == 8'h20) take = !flags[lasx_pkg::FLAG_Z];
                     else if (op == 8'h28) take = flags[lasx_pkg::FLAG_Z];
                     else if (op == 8'h30) take = !flags[lasx_pkg::FLAG_C];
                     else if (op == 8'h38) take = flags[lasx_pkg::FLAG_C];
                     nxt = take ? jr : pc + 16'd2;
                  end
               end
               4'h1: begin wr16(row, imm16); nxt = pc + 16'd3; end
               4'h2: begin
                  e.we = 1'b1; e.wdata = {8'h00, acc};
                  e.waddr = row[1] ? hl : rd16(row);
                  if (row == 2'd2) hl = hl + 16'd1;
                  if (row == 2'd3) hl = hl - 16'd1;
               end
               4'hA: begin
                  acc = mem;
                  if (row == 2'd2) hl = hl + 16'd1;
                  if (row == 2'd3) hl = hl - 16'd1;
               end
               4'h3: wr16(row, rd16(row) + 16'd1);
               4'hB: wr16(row, rd16(row) - 16'd1);
               4'h4, 4'hC, 4'h5, 4'hD: begin
                  if (r8 == 3'd6) begin
                     e.we = 1'b1; e.waddr = hl;
                     e.wdata = {8'h00, incdec(mem, col[0])};
                  end else wr8(r8, incdec(rd8(r8), col[0]));
               end
               4'h6, 4'hE: begin
                  if (r8 == 3'd6) begin
                     e.we = 1'b1; e.waddr = hl; e.wdata = {8'h00, lo};
                  end else wr8(r8, lo);
                  nxt = pc + 16'd2;
               end
               4'h9: begin
                  other = rd16(row);
                  sum = {1'b0, hl} + {1'b0, other};
                  flags[lasx_pkg::FLAG_N] = 1'b0;
                  flags[lasx_pkg::FLAG_H] =
                     ({1'b0, hl[11:0]} + {1'b0, other[11:0]}) > 13'h0FFF;
                  flags[lasx_pkg::FLAG_C] = sum[16];
                  hl = sum[15:0];
               end
               4'h7: begin
                  a = acc;
                  case (row)
                     2'd0: begin acc = {a[6:0], a[7]}; rot_flags(a[7]); end
                     2'd1: begin
                        acc = {a[6:0], flags[lasx_pkg::FLAG_C]}; rot_flags(a[7]);
                     end
                     2'd2: begin
                        // decimal adjust: carry only ever set on the add side
                        a9 = {1'b0, a};
                        if (!flags[lasx_pkg::FLAG_N]) begin
                           if (flags[lasx_pkg::FLAG_C] || a > 8'h99) begin
                              a9 = a9 + 9'h60; flags[lasx_pkg::FLAG_C] = 1'b1;
                           end
                           if (flags[lasx_pkg::FLAG_H] || a9[3:0] > 4'h9) a9 = a9 + 9'h06;
                        end else begin
                           if (flags[lasx_pkg::FLAG_C]) a9 = a9 - 9'h60;
                           if (flags[lasx_pkg::FLAG_H]) a9 = a9 - 9'h06;
                        end
                        acc = a9[7:0];
                        flags[lasx_pkg::FLAG_Z] = (acc == 8'h00);
                        flags[lasx_pkg::FLAG_H] = 1'b0;
                     end
                     default: begin
                        flags[lasx_pkg::FLAG_N] = 1'b0; flags[lasx_pkg::FLAG_H] = 1'b0;
                        flags[lasx_pkg::FLAG_C] = 1'b1;
                     end
                  endcase
               end
               default: begin
                  a = acc;
                  case (row)
                     2'd0: begin acc = {a[0], a[7:1]}; rot_flags(a[0]); end
                     2'd1: begin
                        acc = {flags[lasx_pkg::FLAG_C], a[7:1]}; rot_flags(a[0]);
                     end
                     2'd2: begin
                        acc = ~a; flags[lasx_pkg::FLAG_N] = 1'b1;
                        flags[lasx_pkg::FLAG_H] = 1'b1;
                     end
                     default: begin
                        flags[lasx_pkg::FLAG_N] = 1'b0; flags[lasx_pkg::FLAG_H] = 1'b0;
                        flags[lasx_pkg::FLAG_C] = ~flags[lasx_pkg::FLAG_C];
                     end
                  endcase
               end
            endcase
         end
         pc = nxt;
         e.pc = pc; e.acc = acc; e.flags = flags; e.bc = bc; e.de = de;
         e.hl = hl; e.sp = sp;
         pending.push_back(e);
      endfunction

      function void check_result(exec_result_type got);
         exec_result_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat: got %p", got);
            return;
         end
         e = pending.pop_front();
         if (got != e) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result differs: exp %p got %p", e, got);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_opcode = 8'h00, req_imm_low = 8'h00, req_imm_high = 8'h00;
   logic [7:0]  req_operand_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_write_enable, rsp_write_word, rsp_unknown_op;
   logic [15:0] rsp_write_addr, rsp_write_data, rsp_next_pc;
   logic [7:0]  rsp_acc_out, rsp_flags_out;
   logic [15:0] rsp_bc_out, rsp_de_out, rsp_hl_out, rsp_sp_out;

   exec_scoreboard cpu_sb = new();
   int send_idle_pct = 0;   // sender gap chance, percent
   int recv_stall_pct = 0;  // receiver stall chance, percent

   cpu_load_alu_subset_execute i_dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Receiver: random stall, check each accepted beat.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         cpu_sb.check_result('{rsp_write_enable, rsp_write_addr, rsp_write_data,
            rsp_write_word, rsp_next_pc, rsp_acc_out, rsp_flags_out, rsp_bc_out,
            rsp_de_out, rsp_hl_out, rsp_sp_out, rsp_unknown_op});
      rsp_stall <= !reset && ($urandom_range(99) < recv_stall_pct);
   end

   // One beat: optional idle cycles, then hold valid until accepted.
   // Valid stays high across back-to-back beats (single NBA per edge).
   task automatic send_instr(logic [7:0] op, logic [7:0] lo, logic [7:0] hi,
                             logic [7:0] mem);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op; req_imm_low <= lo; req_imm_high <= hi;
      req_operand_byte <= mem;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      cpu_sb.note_instr(op, lo, hi, mem);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (cpu_sb.pending.size() != 0) @(posedge clock);
   endtask

   // Random instruction: mostly implemented opcodes, some unknown.
   task automatic send_random();
      logic [7:0] op;
      op = ($urandom_range(9) == 0) ? 8'($urandom_range(255, 80))
                                    : 8'($urandom_range(79));
      send_instr(op, 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   initial begin
      cpu_sb.power_on();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Directed: extremes, rotates, DAA, jumps, wrap, store SP, unknown.
      send_instr(8'h00, 8'h00, 8'h00, 8'h00);
      send_instr(8'h10, 8'hFF, 8'hFF, 8'hFF);
      send_instr(8'h08, 8'hFF, 8'hFF, 8'h00);
      send_instr(8'h31, 8'hFF, 8'hFF, 8'h00);  // SP = FFFF
      send_instr(8'h33, 8'h00, 8'h00, 8'h00);  // SP wraps to 0
      send_instr(8'h21, 8'hFF, 8'hFF, 8'h00);
      send_instr(8'h29, 8'h00, 8'h00, 8'h00);  // ADD HL,HL carries
      send_instr(8'h3E, 8'h99, 8'h00, 8'h00);
      send_instr(8'h27, 8'h00, 8'h00, 8'h00);  // DAA
      send_instr(8'h07, 8'h00, 8'h00, 8'h00);
      send_instr(8'h0F, 8'h00, 8'h00, 8'h00);
      send_instr(8'h17, 8'h00, 8'h00, 8'h00);
      send_instr(8'h1F, 8'h00, 8'h00, 8'h00);
      send_instr(8'h2F, 8'h00, 8'h00, 8'h00);
      send_instr(8'h37, 8'h00, 8'h00, 8'h00);
      send_instr(8'h3F, 8'h00, 8'h00, 8'h00);
      send_instr(8'h34, 8'h00, 8'h00, 8'hFF);  // INC (HL) to zero
      send_instr(8'h35, 8'h00, 8'h00, 8'h00);
      send_instr(8'h18, 8'h80, 8'h00, 8'h00);  // JR back
      send_instr(8'h20, 8'h7F, 8'h00, 8'h00);
      send_instr(8'h38, 8'hFE, 8'h00, 8'h00);
      send_instr(8'h22, 8'h00, 8'h00, 8'h00);
      send_instr(8'h3A, 8'h00, 8'h00, 8'hA5);
      send_instr(8'h46, 8'h00, 8'h00, 8'h5A);
      send_instr(8'hFF, 8'hFF, 8'hFF, 8'hFF);
      drain();  // hold off until every result is back
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
            default: begin send_idle_pct = 10; recv_stall_pct = 10; end
         endcase
         for (int n = 0; n < 385; n++) send_random();
      end
      drain();
      recv_stall_pct = 0;
      repeat (5) @(posedge clock);
      if (cpu_sb.mismatches == 0 && cpu_sb.pending.size() == 0)
         $display("cpu_load_alu_subset_execute: match");
      else
         $display("cpu_load_alu_subset_execute: mismatch");
      $finish;
   end

   initial begin
      #4000000;
      $display("cpu_load_alu_subset_execute: mismatch");
      $finish;
   end
endmodule

/* sim.f */
src/lasx_pkg.sv
src/lasx_exec.sv
src/cpu_load_alu_subset_execute.sv
src/lasx_checker.sv
test/tb.sv
